// ===== hdl/subset_sum_transform_mod_prime_top_macros.svh =====
// Assertion macros used by the RTL of the subset-sum transform block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SUBSET_SUM_TRANSFORM_MOD_PRIME_TOP_MACROS_SVH
`define SUBSET_SUM_TRANSFORM_MOD_PRIME_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSTMP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSTMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sstmp_pkg.sv =====
package sstmp_pkg;

    localparam int MAX_LOG = 16;
    localparam int ADDR_W  = MAX_LOG;
    localparam int INDEX_W = 16;
    localparam int VAL_W   = 30;
    localparam int LOG_W   = 5;
    localparam int CMD_W   = 2;

    localparam logic [31:0] PRIME_MOD = 32'd1000000007;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_XFORM = 2'd2;

    // Operands of the shared modular add/subtract unit.
    typedef struct packed {
        logic             sub;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } mod_op_t;

endpackage

// ===== hdl/sstmp_modaddsub.sv =====
// Modular add or subtract with one conditional correction by the prime.
module sstmp_modaddsub (
    input  sstmp_pkg::mod_op_t             op,
    output logic [sstmp_pkg::VAL_W-1:0]    result
);

    logic [31:0] a_ext;
    logic [31:0] b_ext;
    logic [31:0] addend;
    logic [31:0] sum;
    logic [31:0] reduced;

    always_comb
    begin
        a_ext   = 32'(op.a);
        b_ext   = 32'(op.b);
        addend  = op.sub ? (sstmp_pkg::PRIME_MOD - b_ext) : b_ext;
        sum     = a_ext + addend;
        reduced = (sum >= sstmp_pkg::PRIME_MOD) ? (sum - sstmp_pkg::PRIME_MOD) : sum;
        result  = reduced[sstmp_pkg::VAL_W-1:0];
    end

endmodule

// ===== hdl/subset_sum_transform_mod_prime_top.sv =====
// Subset-sum (OR-convolution zeta / Mobius) transform over a vector of
// residues modulo 1000000007. The block holds a vector of 65536 elements of
// 30 bits in one on-chip memory with a single write port. A write request
// stores the value, reduced once by the prime if it is not already reduced.
// A read request fetches its element into a register, and its result is then
// loaded into an output register and held there until taken; writes keep
// flowing while that result waits, and a further read waits until the output
// register is free. A transform request runs the in-place transform over the
// first 2^log_size elements (log_size above 16 acts as 16) and occupies the
// block until it is done: every butterfly has a read state that reads its
// pair of elements and an update state that writes back the updated upper
// element through the one write port, and the butterflies run one after
// another through a single modular add/subtract unit. A transform with log
// size zero finishes at once. Elements must be written before they are read,
// and the memory has no reset and no clearing pass. The log_size register is
// written through cfg_write and cfg_data and should only change while the
// block is idle.
module subset_sum_transform_mod_prime_top (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_write,
    input  logic [sstmp_pkg::LOG_W-1:0]     cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sstmp_pkg::CMD_W-1:0]     command,
    input  logic [sstmp_pkg::INDEX_W-1:0]   index,
    input  logic [sstmp_pkg::VAL_W-1:0]     value,
    input  logic                            inverse,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sstmp_pkg::VAL_W-1:0]     read_value
);

`include "subset_sum_transform_mod_prime_top_macros.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_EX   = 2'd2;

    localparam int ADDR_W = sstmp_pkg::ADDR_W;
    localparam int VAL_W  = sstmp_pkg::VAL_W;
    localparam int LOG_W  = sstmp_pkg::LOG_W;

    // The vector itself; no reset, contents are defined only once written.
    logic [VAL_W-1:0]  vector_store [2**ADDR_W];

    logic [1:0]        state_reg, state_next;
    logic [LOG_W-1:0]  log_size_reg, log_size_next;
    logic [LOG_W-1:0]  lg_reg, lg_next;
    logic [LOG_W-1:0]  pass_reg, pass_next;
    logic [ADDR_W-1:0] mask_reg, mask_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic [ADDR_W-1:0] jlast_reg, jlast_next;
    logic              inv_reg, inv_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  out_data_reg;
    logic [VAL_W-1:0]  rd_a_reg;
    logic [VAL_W-1:0]  rd_b_reg;

    logic              in_acc;
    logic [LOG_W-1:0]  eff_lg;
    logic [ADDR_W-1:0] req_addr;
    logic [ADDR_W-1:0] bit_oh;
    logic [ADDR_W-1:0] lo_addr;
    logic [ADDR_W-1:0] hi_addr;
    logic [ADDR_W-1:0] rd_addr_a;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [VAL_W-1:0]  mem_wdata;
    sstmp_pkg::mod_op_t unit_op;
    logic              pass_done;
    logic              last_pass;

    // A read may only be taken when the output register is free; nothing is
    // taken while a read result is on its way or a transform is running.
    assign in_stall = (state_reg != ST_IDLE) || rd_pend_reg
                   || (out_valid_reg && (command == sstmp_pkg::CMD_READ));
    assign in_acc   = in_valid && !in_stall;

    assign req_addr = ADDR_W'(index);
    assign eff_lg   = (log_size_reg > LOG_W'(sstmp_pkg::MAX_LOG))
                    ? LOG_W'(sstmp_pkg::MAX_LOG) : log_size_reg;

    // The butterfly counter has the current bit squeezed out; reinsert a zero
    // there for the lower element and a one for the upper element.
    assign bit_oh  = ((mask_reg << 1) | ADDR_W'(1)) & ~mask_reg;
    assign lo_addr = ((j_reg & ~mask_reg) << 1) | (j_reg & mask_reg);
    assign hi_addr = lo_addr | bit_oh;

    assign rd_addr_a = (state_reg == ST_IDLE) ? req_addr : lo_addr;

    // The shared unit reduces incoming write values (adding zero) and, in
    // the update cycle of a butterfly, combines the upper and lower elements.
    always_comb
    begin
        if (state_reg == ST_EX)
        begin
            unit_op.sub = inv_reg;
            unit_op.a   = rd_b_reg;
            unit_op.b   = rd_a_reg;
        end
        else
        begin
            unit_op.sub = 1'b0;
            unit_op.a   = value;
            unit_op.b   = '0;
        end
    end

    sstmp_modaddsub u_unit (
        .op     (unit_op),
        .result (mem_wdata)
    );

    assign mem_we    = (in_acc && (command == sstmp_pkg::CMD_WRITE)) || (state_reg == ST_EX);
    assign mem_waddr = (state_reg == ST_EX) ? hi_addr : req_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vector_store[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= vector_store[rd_addr_a];
        rd_b_reg <= vector_store[hi_addr];
    end

    assign pass_done = (j_reg == jlast_reg);
    assign last_pass = (pass_reg == (lg_reg - LOG_W'(1)));

    // Transform sequencer: each butterfly is a read state then an update state.
    always_comb
    begin
        state_next    = state_reg;
        lg_next       = lg_reg;
        pass_next     = pass_reg;
        mask_next     = mask_reg;
        j_next        = j_reg;
        jlast_next    = jlast_reg;
        inv_next      = inv_reg;
        log_size_next = cfg_write ? cfg_data : log_size_reg;
        rd_pend_next  = in_acc && (command == sstmp_pkg::CMD_READ);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (command == sstmp_pkg::CMD_XFORM))
                begin
                    lg_next    = eff_lg;
                    pass_next  = '0;
                    mask_next  = '0;
                    j_next     = '0;
                    jlast_next = (ADDR_W'(1) << (eff_lg - LOG_W'(1))) - ADDR_W'(1);
                    inv_next   = inverse;
                    if (eff_lg != '0)
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_EX;
            end
            ST_EX:
            begin
                if (pass_done)
                begin
                    j_next = '0;
                    if (last_pass)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pass_next  = pass_reg + LOG_W'(1);
                        mask_next  = (mask_reg << 1) | ADDR_W'(1);
                        state_next = ST_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + ADDR_W'(1);
                    state_next = ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output register is loaded the cycle after a read's memory access.
    assign out_valid_next = rd_pend_reg || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            log_size_reg  <= LOG_W'(sstmp_pkg::MAX_LOG);
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            log_size_reg  <= log_size_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lg_reg    <= lg_next;
        pass_reg  <= pass_next;
        mask_reg  <= mask_next;
        j_reg     <= j_next;
        jlast_reg <= jlast_next;
        inv_reg   <= inv_next;
        if (rd_pend_reg)
        begin
            out_data_reg <= rd_a_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_data_reg;

    `SSTMP_ASSERT_NOW(a_rd_slot_free, rd_pend_reg, !out_valid_reg,
        "read result in flight while the output register is occupied")
    `SSTMP_ASSERT_NEXT(a_rd_delivers, rd_pend_reg, out_valid_reg,
        "read result was not loaded into the output register")
    `SSTMP_ASSERT_NEXT(a_rd_then_ex, state_reg == ST_RD, state_reg == ST_EX,
        "butterfly read cycle not followed by its update cycle")
    `SSTMP_ASSERT_NOW(a_lower_bit_clear, state_reg == ST_EX,
        ((lo_addr & bit_oh) == '0) && ((hi_addr & bit_oh) != '0),
        "butterfly pair does not differ in the current bit")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

// Testbench for the subset-sum transform block. Requests go in on a valid/stall
// channel and read results come back on a second valid/stall channel. A shadow
// copy of the vector and of log_size is kept here and updated on every accepted
// request, so each read result can be compared with the value the vector
// should hold at that point in the request stream.
module tb;

    localparam int          CMD_W     = sstmp_pkg::CMD_W;
    localparam int          VAL_W     = sstmp_pkg::VAL_W;
    localparam int          LOG_W     = sstmp_pkg::LOG_W;
    localparam int          INDEX_W   = sstmp_pkg::INDEX_W;
    localparam int          ADDR_W    = sstmp_pkg::ADDR_W;
    localparam int          MAX_LOG   = sstmp_pkg::MAX_LOG;
    localparam logic [31:0] PRIME_MOD = sstmp_pkg::PRIME_MOD;

    // Command code 3 has no meaning; the block must drop such requests.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int          CLK_PERIOD   = 10;
    localparam int          RESET_CYCLES = 4;
    localparam int unsigned STORE_DEPTH  = 1 << MAX_LOG;
    localparam int unsigned VAL_MAX      = (1 << VAL_W) - 1;
    localparam int unsigned LOG_MAX      = (1 << LOG_W) - 1;

    // The largest transform issued here runs at log size 8 and keeps the block
    // busy with nothing accepted for longer than the long receiver hold-off
    // lasts. The limit on a quiet stretch is several times the longer of the two.
    localparam int unsigned STALL_LIMIT   = 20_000;
    // Length of the long receiver hold-off used to fill the block up.
    localparam int unsigned HOLD_CYCLES   = 600;
    // Extra cycles allowed after the last result before the block counts as idle.
    localparam int unsigned SETTLE_CYCLES = 8;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_write  = 1'b0;
    logic [LOG_W-1:0]     cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [CMD_W-1:0]     command    = sstmp_pkg::CMD_WRITE;
    logic [INDEX_W-1:0]   index      = '0;
    logic [VAL_W-1:0]     value      = '0;
    logic                 inverse    = 1'b0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [VAL_W-1:0]     read_value;

    // Shadow state, owned by the request tracker below.
    logic [VAL_W-1:0]     shadow_mem [STORE_DEPTH];
    int unsigned          shadow_log = MAX_LOG;
    int unsigned          xform_busy_cycles = 0;
    logic [VAL_W-1:0]     expected_read_values [$];

    // Stimulus bookkeeping: which elements have been written at least once.
    // Reads and transforms only ever touch elements marked here, because the
    // block's memory has no reset.
    bit                   seeded [STORE_DEPTH];
    int unsigned          seeded_q [$];

    int unsigned          burst_left  = 0;
    int unsigned          hold_asked  = 0;
    int unsigned          hold_served = 0;
    int unsigned          hold_left   = 0;
    int unsigned          rx_cycle    = 0;
    int unsigned          idle_cycles = 0;
    int unsigned          fail_count  = 0;

    subset_sum_transform_mod_prime_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .index      (index),
        .value      (value),
        .inverse    (inverse),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Arithmetic of the shadow vector
    // ------------------------------------------------------------------------

    // A written value below twice the prime is brought into range by one
    // subtraction.
    function automatic logic [VAL_W-1:0] reduce_residue(input logic [VAL_W-1:0] raw);
        logic [31:0] acc;
        acc = {2'b00, raw};
        if (acc >= PRIME_MOD)
            acc = acc - PRIME_MOD;
        return acc[VAL_W-1:0];
    endfunction

    // One butterfly: the upper element gains or loses the lower one.
    function automatic logic [VAL_W-1:0] combine_pair(input logic [VAL_W-1:0] upper,
                                                      input logic [VAL_W-1:0] lower,
                                                      input logic inv);
        logic [31:0] acc;
        if (inv)
            acc = {2'b00, upper} + PRIME_MOD - {2'b00, lower};
        else
            acc = {2'b00, upper} + {2'b00, lower};
        if (acc >= PRIME_MOD)
            acc = acc - PRIME_MOD;
        return acc[VAL_W-1:0];
    endfunction

    // In-place OR transform over the first 2^log2n elements, bit by bit from
    // the lowest. Every element with the bit set takes in its partner with the
    // bit cleared.
    function automatic void apply_subset_transform(input int unsigned log2n,
                                                   input logic inv);
        int unsigned       span;
        int unsigned       half;
        int unsigned       base;
        int unsigned       k;
        logic [ADDR_W-1:0] lo_idx;
        logic [ADDR_W-1:0] hi_idx;
        span = 1 << log2n;
        for (half = 1; half < span; half = half << 1)
            for (base = 0; base < span; base = base + 2 * half)
                for (k = 0; k < half; k++)
                begin
                    lo_idx = ADDR_W'(base + k);
                    hi_idx = ADDR_W'(base + half + k);
                    shadow_mem[hi_idx] = combine_pair(shadow_mem[hi_idx],
                                                      shadow_mem[lo_idx], inv);
                end
    endfunction

    // ------------------------------------------------------------------------
    // Request tracker: follows every accepted request and configuration write.
    // All DUT signals are sampled at the clock edge, before any update of the
    // edge lands, so the values seen here are the ones the block acted on.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : request_tracker
        int unsigned eff_log;
        if (xform_busy_cycles > 0)
            xform_busy_cycles--;
        if (rst_n && cfg_write)
            shadow_log = 32'(cfg_data);
        if (rst_n && in_valid && !in_stall)
        begin
            case (command)
                sstmp_pkg::CMD_WRITE:
                    shadow_mem[ADDR_W'(index)] = reduce_residue(value);
                sstmp_pkg::CMD_READ:
                    expected_read_values.push_back(shadow_mem[ADDR_W'(index)]);
                sstmp_pkg::CMD_XFORM:
                begin
                    // A log size above the vector's maximum acts as the maximum.
                    eff_log = (shadow_log > MAX_LOG) ? MAX_LOG : shadow_log;
                    apply_subset_transform(eff_log, inverse);
                    xform_busy_cycles = (eff_log == 0) ? 1 :
                                        2 * eff_log * (1 << (eff_log - 1)) + 1;
                end
                default:
                    ; // The unused command code changes nothing.
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each accepted read result is matched against the oldest
    // outstanding read.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_checker
        logic [VAL_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_read_values.size() == 0)
            begin
                $error("read_value: expected no result, got %0d", read_value);
                fail_count++;
            end
            else
            begin
                want = expected_read_values.pop_front();
                if (read_value !== want)
                begin
                    $error("read_value: expected %0d, got %0d", want, read_value);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: its stall pattern rotates between no stall, light and heavy
    // random stall and a fixed one-in-three pattern. A test can ask for a long
    // hold-off, which this process counts out by itself.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : receiver
        rx_cycle++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            case ((rx_cycle >> 8) % 4)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= (rx_cycle % 3 == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a run that accepts nothing on either channel for too long has
    // hung.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly reduced residues, with zero, the largest residue and values that
    // still need one subtraction mixed in.
    function automatic logic [VAL_W-1:0] random_residue();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return VAL_W'(PRIME_MOD - 32'd1);
        if (pick < 5)
            return VAL_W'($urandom_range(PRIME_MOD, VAL_MAX));
        return VAL_W'($urandom_range(0, PRIME_MOD - 1));
    endfunction

    // Any 30-bit pattern, for fields the command does not use.
    function automatic logic [VAL_W-1:0] random_raw();
        return VAL_W'($urandom_range(0, VAL_MAX));
    endfunction

    function automatic logic random_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [INDEX_W-1:0] random_index(input int unsigned span);
        return INDEX_W'($urandom_range(0, span - 1));
    endfunction

    function automatic logic [INDEX_W-1:0] pick_seeded();
        return INDEX_W'(seeded_q[$urandom_range(0, seeded_q.size() - 1)]);
    endfunction

    // Offers one request and returns at the edge where it is taken. The sender
    // works in bursts: valid stays high from one request to the next inside a
    // burst and drops between bursts. Callers issue the next request in the same
    // time step, so a burst has no holes.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                                input logic [VAL_W-1:0] val, input logic inv);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(48, 160)
                                                      : $urandom_range(1, 24);
        end
        if (cmd == sstmp_pkg::CMD_WRITE && !seeded[idx])
        begin
            seeded[idx] = 1'b1;
            seeded_q.push_back(32'(idx));
        end
        in_valid <= 1'b1;
        command  <= cmd;
        index    <= idx;
        value    <= val;
        inverse  <= inv;
        burst_left--;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Waits until the block has nothing left to do: every read answered and
    // any transform run to its end, plus a margin of SETTLE_CYCLES. The first
    // edge lets the tracker catch up with a request taken in this time step.
    task automatic settle_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_read_values.size() != 0 || xform_busy_cycles > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The register only changes while the block is idle.
    task automatic set_log_size(input logic [LOG_W-1:0] log_cfg);
        settle_block();
        cfg_write <= 1'b1;
        cfg_data  <= log_cfg;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Extremes of the fields, values that need reducing, the unused command,
    // a transform over a single element and both directions over four.
    task automatic test_directed_edges();
        send_request(sstmp_pkg::CMD_WRITE, 16'h0000, '0, 1'b0);
        send_request(sstmp_pkg::CMD_WRITE, 16'hFFFF, VAL_W'(PRIME_MOD - 32'd1), 1'b1);
        // The prime itself is stored as zero.
        send_request(sstmp_pkg::CMD_WRITE, 16'h5555, VAL_W'(PRIME_MOD), 1'b0);
        // The largest 30-bit value is reduced once.
        send_request(sstmp_pkg::CMD_WRITE, 16'hAAAA, {VAL_W{1'b1}}, 1'b1);
        // This must not overwrite element zero.
        send_request(CMD_UNUSED, 16'h0000, 30'd12345, 1'b1);
        send_request(sstmp_pkg::CMD_READ, 16'h0000, {VAL_W{1'b1}}, 1'b1);
        send_request(sstmp_pkg::CMD_READ, 16'hFFFF, '0, 1'b0);
        send_request(sstmp_pkg::CMD_READ, 16'h5555, '0, 1'b0);
        send_request(sstmp_pkg::CMD_READ, 16'hAAAA, '0, 1'b1);

        // With a single element in use a transform leaves it alone.
        set_log_size(LOG_W'(0));
        send_request(sstmp_pkg::CMD_XFORM, 16'hFFFF, {VAL_W{1'b1}}, 1'b0);
        send_request(sstmp_pkg::CMD_READ, 16'h0000, '0, 1'b0);
        send_request(sstmp_pkg::CMD_XFORM, 16'h0000, '0, 1'b1);
        send_request(sstmp_pkg::CMD_READ, 16'h0000, '0, 1'b0);

        // Large residues make the forward sums wrap and the inverse borrow.
        set_log_size(LOG_W'(2));
        send_request(sstmp_pkg::CMD_WRITE, 16'h0001, VAL_W'(PRIME_MOD - 32'd1), 1'b0);
        send_request(sstmp_pkg::CMD_WRITE, 16'h0002, VAL_W'(PRIME_MOD - 32'd2), 1'b0);
        send_request(sstmp_pkg::CMD_WRITE, 16'h0003, 30'd5, 1'b0);
        send_request(sstmp_pkg::CMD_XFORM, 16'h0000, '0, 1'b0);
        send_request(sstmp_pkg::CMD_READ, 16'h0000, '0, 1'b0);
        send_request(sstmp_pkg::CMD_READ, 16'h0001, '0, 1'b0);
        send_request(sstmp_pkg::CMD_READ, 16'h0002, '0, 1'b0);
        send_request(sstmp_pkg::CMD_READ, 16'h0003, '0, 1'b0);
        send_request(sstmp_pkg::CMD_XFORM, 16'h0000, '0, 1'b1);
        send_request(sstmp_pkg::CMD_READ, 16'h0003, '0, 1'b0);
    endtask

    // Random traffic at a range of small log sizes. Each setting first fills
    // the elements in use, so that transforms only ever see written data, and
    // then mixes writes, reads, transforms in both directions and the unused
    // command. Some writes and reads land outside the elements in use.
    task automatic test_random_traffic();
        int unsigned        log_plan  [7] = '{0, 1, 2, 3, 4, 5, 8};
        int unsigned        item_plan [7] = '{100, 150, 200, 200, 200, 200, 300};
        int unsigned        p;
        int unsigned        i;
        int unsigned        span;
        int unsigned        roll;
        logic [INDEX_W-1:0] idx;
        for (p = 0; p < 7; p++)
        begin
            set_log_size(LOG_W'(log_plan[p]));
            span = 1 << log_plan[p];
            for (i = 0; i < span; i++)
                send_request(sstmp_pkg::CMD_WRITE, INDEX_W'(i), random_residue(),
                             random_bit());
            for (i = 0; i < item_plan[p]; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 40)
                begin
                    if ($urandom_range(0, 3) == 0)
                        idx = random_index(STORE_DEPTH);
                    else
                        idx = random_index(span);
                    send_request(sstmp_pkg::CMD_WRITE, idx, random_residue(), random_bit());
                end
                else if (roll < 80)
                begin
                    if ($urandom_range(0, 3) == 0)
                        idx = pick_seeded();
                    else
                        idx = random_index(span);
                    send_request(sstmp_pkg::CMD_READ, idx, random_raw(), random_bit());
                end
                else if (roll < 92)
                    send_request(sstmp_pkg::CMD_XFORM, random_index(STORE_DEPTH),
                                 random_raw(), random_bit());
                else
                    send_request(CMD_UNUSED, random_index(STORE_DEPTH),
                                 random_raw(), random_bit());
            end
        end
    endtask

    // The receiver holds off for a long stretch while reads and writes keep
    // coming. One read result parks in the output register, the next read
    // backs up into the input and the sender sees a stall until the hold ends.
    task automatic test_output_backpressure();
        int unsigned i;
        settle_block();
        hold_asked++;
        for (i = 0; i < 160; i++)
        begin
            if ($urandom_range(0, 9) < 6)
                send_request(sstmp_pkg::CMD_READ, pick_seeded(), random_raw(), random_bit());
            else
                send_request(sstmp_pkg::CMD_WRITE, random_index(STORE_DEPTH),
                             random_residue(), random_bit());
        end
    endtask

    // The register at its largest code: writes and reads anywhere in the
    // vector still reach the store, and the unused command is still dropped.
    task automatic test_large_log_size();
        int unsigned i;
        set_log_size(LOG_W'(LOG_MAX));
        send_request(sstmp_pkg::CMD_READ, 16'h0000, '0, 1'b0);
        send_request(sstmp_pkg::CMD_READ, 16'hFFFF, '0, 1'b0);
        for (i = 0; i < 40; i++)
        begin
            if (i % 8 == 7)
                send_request(CMD_UNUSED, pick_seeded(), random_raw(), random_bit());
            else if (i % 2 == 0)
                send_request(sstmp_pkg::CMD_WRITE, random_index(STORE_DEPTH),
                             random_residue(), random_bit());
            else
                send_request(sstmp_pkg::CMD_READ, pick_seeded(), random_raw(), random_bit());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence. Reset is held once at the start, then the tests run
    // in turn.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_random_traffic();
        test_output_backpressure();
        test_large_log_size();

        settle_block();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sstmp_pkg.sv
hdl/sstmp_modaddsub.sv
hdl/subset_sum_transform_mod_prime_top.sv
sim/tb.sv
